@@ hw/rtl/ras_pkg.sv @@
// ----------------------------------------------------------------------------
// ras_pkg: room allocation scheduler shared types and constants
// Widths, room index type, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package ras_pkg;

   localparam int MAX_ROOMS  = 16;
   localparam int ROOM_W     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
   localparam int OUT_ROOM_W = 4;
   localparam int TIME_W     = 48;
   localparam int CNT_W      = 32;
   localparam int IN_TIME_W  = 32;
   localparam int CSR_W      = 5;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   localparam logic [CSR_W-1:0] ROOMS_RESET = CSR_W'(16);

   typedef logic [ROOM_W-1:0]     room_type;
   typedef logic [OUT_ROOM_W-1:0] out_room_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [IN_TIME_W-1:0]  in_time_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic update;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

   function automatic out_room_type to_out_room(input room_type r);
      out_room_type o;
      o = '0;
      for (int i = 0; i < OUT_ROOM_W; i++) begin
         if (i < ROOM_W) begin
            o[i] = r[i];
         end
      end
      return o;
   endfunction

endpackage

@@ hw/rtl/ras_ctrl.sv @@
// ----------------------------------------------------------------------------
// ras_ctrl: room allocation scheduler controller
// Sequences load, room scan, room update and result publish per item.
// ----------------------------------------------------------------------------
module ras_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ras_pkg::status_type status,
   output ras_pkg::cmd_type    cmd
);

   ras_pkg::state_type state_ff;
   ras_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ras_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ras_pkg::ST_SCAN;
            end
         end
         ras_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ras_pkg::ST_UPDATE;
            end
         end
         ras_pkg::ST_UPDATE: begin
            state_in = ras_pkg::ST_PUBLISH;
         end
         ras_pkg::ST_PUBLISH: begin
            if (status.out_free) begin
               state_in = ras_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ras_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ras_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ras_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ras_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ras_pkg::ST_PUBLISH: begin
            cmd.publish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ras_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.update, cmd.publish}))
      else $error("ras_ctrl: more than one command active");

   a_update_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.scan))
      else $error("ras_ctrl: update without a preceding scan");

endmodule

@@ hw/rtl/ras_datapath.sv @@
// ----------------------------------------------------------------------------
// ras_datapath: room allocation scheduler datapath
// Room state, one-room-per-cycle scan, assignment update and result register.
// ----------------------------------------------------------------------------
module ras_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ras_pkg::cmd_type                    cmd,
   output ras_pkg::status_type                 status,
   input  logic                                req_tuser,
   input  logic [ras_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_we,
   input  logic [ras_pkg::CSR_W-1:0]           csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ras_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);

   logic [ras_pkg::CSR_W-1:0] rooms_ff;
   ras_pkg::in_time_type      start_ff;
   ras_pkg::in_time_type      end_ff;
   ras_pkg::in_time_type      dur_ff;
   ras_pkg::time_type         busy_until_ff [ras_pkg::MAX_ROOMS];
   logic                      busy_ff       [ras_pkg::MAX_ROOMS];
   ras_pkg::count_type        count_ff      [ras_pkg::MAX_ROOMS];
   ras_pkg::room_type         best_room_ff;
   ras_pkg::count_type        best_count_ff;
   ras_pkg::room_type         idx_ff;
   logic                      found_ff;
   ras_pkg::room_type         free_room_ff;
   ras_pkg::room_type         min_room_ff;
   ras_pkg::time_type         min_bu_ff;
   ras_pkg::room_type         room_ff;
   ras_pkg::count_type        cnt_new_ff;
   ras_pkg::time_type         fin_ff;
   logic                      delayed_ff;
   logic                      rsp_valid_ff;
   ras_pkg::out_room_type     out_room_ff;
   ras_pkg::out_room_type     out_best_ff;
   ras_pkg::time_type         out_fin_ff;
   logic                      out_delayed_ff;

   ras_pkg::room_type    last_idx;
   ras_pkg::in_time_type in_start;
   ras_pkg::in_time_type in_end;
   ras_pkg::time_type    rd_bu;
   logic                 rd_busy;
   logic                 expired;
   logic                 free_now;
   ras_pkg::room_type    room_sel;
   ras_pkg::count_type   rd_cnt;
   ras_pkg::count_type   cnt_inc;
   logic [ras_pkg::TIME_W:0] delay_sum;
   ras_pkg::time_type    fin_sel;
   logic                 better;

   assign in_start = req_tdata[ras_pkg::IN_TIME_W-1:0];
   assign in_end   = req_tdata[ras_pkg::REQ_DATA_W-1:ras_pkg::IN_TIME_W];

   always_comb begin
      if (rooms_ff == '0) begin
         last_idx = '0;
      end else if (32'(rooms_ff) > 32'(ras_pkg::MAX_ROOMS)) begin
         last_idx = ras_pkg::room_type'(ras_pkg::MAX_ROOMS - 1);
      end else begin
         last_idx = ras_pkg::room_type'(rooms_ff - ras_pkg::CSR_W'(1));
      end
   end

   assign rd_bu    = busy_until_ff[idx_ff];
   assign rd_busy  = busy_ff[idx_ff];
   assign expired  = rd_busy && (rd_bu <= ras_pkg::time_type'(start_ff));
   assign free_now = !rd_busy || expired;

   assign room_sel  = found_ff ? free_room_ff : min_room_ff;
   assign rd_cnt    = count_ff[room_sel];
   assign cnt_inc   = (rd_cnt == '1) ? rd_cnt : rd_cnt + ras_pkg::count_type'(1);
   assign delay_sum = {1'b0, min_bu_ff} + (ras_pkg::TIME_W + 1)'(dur_ff);

   always_comb begin
      if (found_ff) begin
         fin_sel = ras_pkg::time_type'(end_ff);
      end else if (delay_sum[ras_pkg::TIME_W]) begin
         fin_sel = '1;
      end else begin
         fin_sel = delay_sum[ras_pkg::TIME_W-1:0];
      end
   end

   assign better = (cnt_new_ff > best_count_ff) ||
                   ((cnt_new_ff == best_count_ff) && (room_ff < best_room_ff));

   assign status.scan_last = (idx_ff == last_idx);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rooms_ff <= ras_pkg::ROOMS_RESET;
      end else if (csr_we) begin
         rooms_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         start_ff <= in_start;
         end_ff   <= in_end;
         dur_ff   <= (in_end > in_start) ? in_end - in_start : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + ras_pkg::room_type'(1);
         if (!found_ff && free_now) begin
            found_ff     <= 1'b1;
            free_room_ff <= idx_ff;
         end
         if ((idx_ff == '0) || (rd_bu < min_bu_ff)) begin
            min_room_ff <= idx_ff;
            min_bu_ff   <= rd_bu;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.load && req_tuser)) begin
         for (int i = 0; i < ras_pkg::MAX_ROOMS; i++) begin
            busy_until_ff[i] <= '0;
            busy_ff[i]       <= 1'b0;
            count_ff[i]      <= '0;
         end
         best_room_ff  <= '0;
         best_count_ff <= '0;
      end else begin
         if (cmd.scan && expired) begin
            busy_ff[idx_ff] <= 1'b0;
         end
         if (cmd.update) begin
            busy_until_ff[room_sel] <= fin_sel;
            busy_ff[room_sel]       <= 1'b1;
            count_ff[room_sel]      <= cnt_inc;
         end
         if (cmd.publish && better) begin
            best_room_ff  <= room_ff;
            best_count_ff <= cnt_new_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         room_ff    <= room_sel;
         cnt_new_ff <= cnt_inc;
         fin_ff     <= fin_sel;
         delayed_ff <= !found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_room_ff    <= ras_pkg::to_out_room(room_ff);
         out_fin_ff     <= fin_ff;
         out_delayed_ff <= delayed_ff;
         out_best_ff    <= ras_pkg::to_out_room(better ? room_ff : best_room_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_best_ff, out_fin_ff, out_room_ff};
   assign rsp_tuser  = out_delayed_ff;

   a_publish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("ras_datapath: result overwritten before it was taken");

   a_room_marked_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> busy_ff[room_ff])
      else $error("ras_datapath: assigned room not marked busy");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (idx_ff <= last_idx))
      else $error("ras_datapath: scan index past last usable room");

endmodule

@@ hw/rtl/room_allocation_scheduler.sv @@
// ----------------------------------------------------------------------------
// room_allocation_scheduler: meeting room scheduler top level
// Assigns each job to the lowest free room or the earliest-freeing room.
// ----------------------------------------------------------------------------
// Each item is loaded on acceptance, then scanned one room per cycle through the
// busy-until table over n usable rooms (1..16), then updated and published to
// the result register; publish waits while an earlier result is still held.
// The next item is accepted once the controller is back in idle.
// The result register lets a new item enter while the last result waits.
// Synchronous reset frees all rooms, clears counts and sets 16 usable rooms.
module room_allocation_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] start_time, [63:32] end_time
   input  logic [ras_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] first_job
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [3:0] assigned_room, [51:4] finish_time, [55:52] most_used_room
   output logic [ras_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] was_delayed
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   // [4:0] rooms_in_use
   input  logic [ras_pkg::CSR_W-1:0]      csr_wdata
);

   ras_pkg::cmd_type    cmd;
   ras_pkg::status_type status;

   ras_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ras_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/tb_room_allocation_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_room_allocation_scheduler: self-checking bench for the room scheduler
// Drives jobs over the request stream, predicts each room assignment and
// compares every result field, across several room counts and stall mixes.
// ----------------------------------------------------------------------------
module tb_room_allocation_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                 first;
      ras_pkg::in_time_type t_start;
      ras_pkg::in_time_type t_end;
   } job_type;

   typedef struct {
      ras_pkg::out_room_type room;
      logic                  delayed;
      ras_pkg::time_type     finish;
      ras_pkg::out_room_type top;
   } alloc_type;

   localparam ras_pkg::time_type  TIME_SAT  = '1;
   localparam ras_pkg::count_type COUNT_SAT = '1;
   localparam int                 PHASES    = 12;
   localparam int                 PHASE_JOBS = 40;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ras_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ras_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we = 1'b0;
   logic [ras_pkg::CSR_W-1:0]      csr_wdata = '0;

   ras_pkg::time_type         room_free_at [ras_pkg::MAX_ROOMS];
   logic                      room_taken   [ras_pkg::MAX_ROOMS];
   ras_pkg::count_type        room_jobs    [ras_pkg::MAX_ROOMS];
   int unsigned               top_room;
   ras_pkg::count_type        top_jobs;
   logic [ras_pkg::CSR_W-1:0] rooms_setting = ras_pkg::ROOMS_RESET;

   job_type     job_q [$];
   alloc_type   alloc_q [$];
   int unsigned n_queued = 0;
   int unsigned n_accepted = 0;
   int unsigned errors = 0;
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   logic        req_taken = 1'b0;
   logic [32:0] job_clock = '0;

   room_allocation_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_rooms();
      for (int i = 0; i < ras_pkg::MAX_ROOMS; i++) begin
         room_free_at[i] = '0;
         room_taken[i]   = 1'b0;
         room_jobs[i]    = '0;
      end
      top_room = 0;
      top_jobs = '0;
   endfunction

   function automatic alloc_type allocate_room(job_type j);
      alloc_type            a;
      int unsigned          n;
      int unsigned          pick;
      logic                 found;
      ras_pkg::in_time_type span;
      logic [ras_pkg::TIME_W:0] sum;
      if (j.first) begin
         clear_rooms();
      end
      span = (j.t_end > j.t_start) ? j.t_end - j.t_start : '0;
      n = rooms_setting;
      if (n < 1) begin
         n = 1;
      end
      if (n > ras_pkg::MAX_ROOMS) begin
         n = ras_pkg::MAX_ROOMS;
      end
      for (int i = 0; i < n; i++) begin
         if (room_taken[i] && room_free_at[i] <= j.t_start) begin
            room_taken[i] = 1'b0;
         end
      end
      found = 1'b0;
      pick  = 0;
      for (int i = 0; i < n; i++) begin
         if (!found && !room_taken[i]) begin
            pick  = i;
            found = 1'b1;
         end
      end
      a.delayed = !found;
      if (found) begin
         a.finish = ras_pkg::time_type'(j.t_end);
      end else begin
         for (int i = 1; i < n; i++) begin
            if (room_free_at[i] < room_free_at[pick]) begin
               pick = i;
            end
         end
         sum = room_free_at[pick] + span;
         a.finish = (sum > TIME_SAT) ? TIME_SAT : sum[ras_pkg::TIME_W-1:0];
      end
      room_free_at[pick] = a.finish;
      room_taken[pick]   = 1'b1;
      if (room_jobs[pick] != COUNT_SAT) begin
         room_jobs[pick]++;
      end
      if (room_jobs[pick] > top_jobs || (room_jobs[pick] == top_jobs && pick < top_room)) begin
         top_jobs = room_jobs[pick];
         top_room = pick;
      end
      a.room = ras_pkg::out_room_type'(pick);
      a.top  = ras_pkg::out_room_type'(top_room);
      return a;
   endfunction

   // predict on acceptance, check on result
   always @(posedge clock) begin
      job_type   j;
      alloc_type want;
      if (reset) begin
         rooms_setting = ras_pkg::ROOMS_RESET;
         clear_rooms();
      end else begin
         if (csr_we) begin
            rooms_setting = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            j.first   = req_tuser;
            j.t_start = req_tdata[31:0];
            j.t_end   = req_tdata[63:32];
            alloc_q.push_back(allocate_room(j));
            req_taken = 1'b1;
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (alloc_q.size() == 0) begin
               $error("unexpected result item: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = alloc_q.pop_front();
               if (rsp_tdata[3:0] !== want.room) begin
                  $error("assigned_room: expected %0d, got %0d", want.room, rsp_tdata[3:0]);
                  errors++;
               end
               if (rsp_tuser !== want.delayed) begin
                  $error("was_delayed: expected %0d, got %0d", want.delayed, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[51:4] !== want.finish) begin
                  $error("finish_time: expected %0d, got %0d", want.finish, rsp_tdata[51:4]);
                  errors++;
               end
               if (rsp_tdata[55:52] !== want.top) begin
                  $error("most_used_room: expected %0d, got %0d", want.top, rsp_tdata[55:52]);
                  errors++;
               end
            end
         end
      end
   end

   // request driver and response backpressure
   always @(negedge clock) begin
      job_type j;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
         req_taken = 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (job_q.size() != 0 && $urandom_range(99) >= send_idle) begin
               j = job_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {j.t_end, j.t_start};
               req_tuser  <= j.first;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic add_job(logic first, ras_pkg::in_time_type t_start,
                          ras_pkg::in_time_type t_end);
      job_type j;
      j.first   = first;
      j.t_start = t_start;
      j.t_end   = t_end;
      job_q.push_back(j);
      n_queued++;
   endtask

   task automatic drain();
      while (n_accepted != n_queued || alloc_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_rooms(int unsigned value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value[ras_pkg::CSR_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_runs(int unsigned count);
      int unsigned left;
      int unsigned len;
      int unsigned gap_max;
      int unsigned dur_max;
      logic        fresh;
      logic [32:0] s;
      logic [32:0] e;
      left = count;
      while (left > 0) begin
         if ($urandom_range(9) == 0) begin
            add_job(1'($urandom_range(1)), $urandom, $urandom);
            left--;
         end else begin
            fresh = ($urandom_range(3) != 0);
            if (fresh) begin
               job_clock = ($urandom_range(4) == 0) ?
                           33'($urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000)) :
                           33'($urandom_range(32'h8000_0000));
            end
            len = $urandom_range(20, 3);
            case ($urandom_range(2))
               0: begin gap_max = 1;  dur_max = 20;     end
               1: begin gap_max = 8;  dur_max = 200;    end
               default: begin gap_max = 40; dur_max = 100000; end
            endcase
            for (int k = 0; k < len && left > 0; k++) begin
               s = job_clock + $urandom_range(gap_max);
               if (s > 33'hFFFF_FFFF) begin
                  s = 33'hFFFF_FFFF;
               end
               job_clock = s;
               case ($urandom_range(19))
                  0: e = 33'($urandom_range(s[31:0]));
                  1: e = s + $urandom;
                  default: e = s + $urandom_range(dur_max, 1);
               endcase
               if (e > 33'hFFFF_FFFF) begin
                  e = 33'hFFFF_FFFF;
               end
               add_job(fresh && k == 0, s[31:0], e[31:0]);
               left--;
            end
         end
      end
   endtask

   initial begin
      int unsigned rooms;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      send_idle = 15;
      recv_idle = 54;

      add_job(1'b1, 32'd0, 32'd0);
      add_job(1'b0, 32'd0, 32'hFFFF_FFFF);
      add_job(1'b0, 32'd5, 32'd3);
      add_job(1'b0, 32'd5, 32'd10);
      add_job(1'b0, 32'd10, 32'd11);
      add_job(1'b1, 32'hFFFF_FFFF, 32'd0);
      add_job(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      write_rooms(1);
      add_job(1'b1, 32'd10, 32'd20);
      add_job(1'b0, 32'd12, 32'd15);
      add_job(1'b0, 32'd13, 32'd13);
      add_job(1'b0, 32'd14, 32'd2);
      add_job(1'b0, 32'd22, 32'hFFFF_FFFF);
      add_job(1'b0, 32'd30, 32'hFFFF_FFFF);
      add_job(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      write_rooms(2);
      add_job(1'b1, 32'd0, 32'd10);
      add_job(1'b0, 32'd1, 32'd5);
      add_job(1'b0, 32'd6, 32'd8);
      add_job(1'b0, 32'd10, 32'd12);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:  rooms = 4;
            1:  rooms = 0;
            2:  rooms = 31;
            3:  rooms = 1;
            4:  rooms = 17;
            5:  rooms = 16;
            6:  rooms = 2;
            7:  rooms = 8;
            8:  rooms = $urandom_range(31);
            9:  rooms = 3;
            10: rooms = 12;
            default: rooms = 16;
         endcase
         write_rooms(rooms);
         if (p < 4) begin
            send_idle = 15;
            recv_idle = 54;
         end else if (p < 8) begin
            send_idle = 54;
            recv_idle = 15;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         add_runs(PHASE_JOBS);
      end

      drain();
      repeat (30) @(negedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
